### sv/psr_pkg.sv
// Shared types and constants for the point slice rasterizer.
// No dependencies; every other file of the block refers to it by scoped name.

package psr_pkg;

    // Grid and number formats
    localparam int GRID_SIZE   = 128;
    localparam int CELL_BITS   = $clog2(GRID_SIZE);
    localparam int CELL_ADDR_W = 2 * CELL_BITS;
    localparam int CELLS       = GRID_SIZE * GRID_SIZE;
    localparam int COORD_BITS  = 16;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int BAND_W      = COORD_BITS + 2;
    localparam int SCALE_W     = 16;
    localparam int HALF_W      = 15;
    localparam int PROD_W      = DIFF_W + SCALE_W + 1;
    localparam int FRAC_SHIFT  = 20;
    localparam int COLOR_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Stream and register port widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Register reset values
    localparam logic signed [COORD_BITS-1:0] X_MIN_RESET   = -16'sd2662;
    localparam logic signed [COORD_BITS-1:0] Y_MIN_RESET   = -16'sd2662;
    localparam logic [SCALE_W-1:0]           X_SCALE_RESET = 16'd25206;
    localparam logic [SCALE_W-1:0]           Y_SCALE_RESET = 16'd25206;
    localparam logic signed [COORD_BITS-1:0] CENTER_RESET  = 16'sd0;
    localparam logic [HALF_W-1:0]            HALF_RESET    = 15'd328;

    // Register indexes (byte address is four times the index)
    typedef enum logic [2:0] {
        REG_X_MIN   = 3'd0,
        REG_Y_MIN   = 3'd1,
        REG_X_SCALE = 3'd2,
        REG_Y_SCALE = 3'd3,
        REG_CENTER  = 3'd4,
        REG_HALF    = 3'd5
    } reg_index_t;

    // Configuration seen by the front end
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_min;
        logic signed [COORD_BITS-1:0] y_min;
        logic [SCALE_W-1:0]           x_scale;
        logic [SCALE_W-1:0]           y_scale;
        logic signed [COORD_BITS-1:0] center;
        logic [HALF_W-1:0]            half;
    } cfg_t;

    // One classified request between front and back
    typedef struct packed {
        logic                   is_read;
        logic [CELL_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]     color;
    } entry_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_RESP
    } back_state_t;

endpackage

### sv/psr_front.sv
// Front end: takes stream requests, tests the slice band and maps points to cells.
// Depends on psr_pkg; pushes classified requests into psr_queue.

module psr_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enable,
    input  psr_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_mode,
    input  logic signed [psr_pkg::COORD_BITS-1:0] in_x,
    input  logic signed [psr_pkg::COORD_BITS-1:0] in_y,
    input  logic signed [psr_pkg::COORD_BITS-1:0] in_z,
    input  logic [psr_pkg::COLOR_W-1:0]     in_color,
    input  logic [psr_pkg::CELL_BITS-1:0]   in_row,
    input  logic [psr_pkg::CELL_BITS-1:0]   in_col,
    input  logic                            q_full,
    output logic                            push,
    output psr_pkg::entry_t                 push_data
);

    // Stage registers
    logic                                s1_valid_reg;
    logic                                s1_mode_reg;
    logic                                s1_band_reg;
    logic [psr_pkg::DIFF_W-1:0]          s1_dx_reg;
    logic [psr_pkg::DIFF_W-1:0]          s1_dy_reg;
    logic [psr_pkg::COLOR_W-1:0]         s1_color_reg;
    logic [psr_pkg::CELL_ADDR_W-1:0]     s1_addr_reg;

    logic                                accept;
    logic                                advance;
    logic [psr_pkg::DIFF_W-1:0]          dx;
    logic [psr_pkg::DIFF_W-1:0]          dy;
    logic signed [psr_pkg::BAND_W-1:0]   band_lo;
    logic signed [psr_pkg::BAND_W-1:0]   band_hi;
    logic signed [psr_pkg::BAND_W-1:0]   z_ext;
    logic                                band_ok;
    logic [psr_pkg::PROD_W-1:0]          prod_x;
    logic [psr_pkg::PROD_W-1:0]          prod_y;
    logic                                x_ok;
    logic                                y_ok;
    logic                                keep;

    // Handshake: stage drains whenever the queue has room
    assign advance  = s1_valid_reg && !q_full;
    assign in_ready = enable && (!s1_valid_reg || !q_full);
    assign accept   = in_valid && in_ready;

    // Offsets from grid edges and the band test, all exact
    assign dx = {in_x[psr_pkg::COORD_BITS-1], in_x}
              - {cfg.x_min[psr_pkg::COORD_BITS-1], cfg.x_min};
    assign dy = {in_y[psr_pkg::COORD_BITS-1], in_y}
              - {cfg.y_min[psr_pkg::COORD_BITS-1], cfg.y_min};
    assign z_ext   = {{2{in_z[psr_pkg::COORD_BITS-1]}}, in_z};
    assign band_lo = {{2{cfg.center[psr_pkg::COORD_BITS-1]}}, cfg.center}
                   - {3'b000, cfg.half};
    assign band_hi = {{2{cfg.center[psr_pkg::COORD_BITS-1]}}, cfg.center}
                   + {3'b000, cfg.half};
    assign band_ok = (z_ext > band_lo) && (z_ext < band_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= in_mode;
            s1_band_reg  <= band_ok;
            s1_dx_reg    <= dx;
            s1_dy_reg    <= dy;
            s1_color_reg <= in_color;
            s1_addr_reg  <= {in_row, in_col};
        end
    end

    // Cell mapping: sign-extended offset times scale, floor by the shift
    assign prod_x = {{(psr_pkg::PROD_W-psr_pkg::DIFF_W){s1_dx_reg[psr_pkg::DIFF_W-1]}}, s1_dx_reg}
                  * {{(psr_pkg::PROD_W-psr_pkg::SCALE_W){1'b0}}, cfg.x_scale};
    assign prod_y = {{(psr_pkg::PROD_W-psr_pkg::DIFF_W){s1_dy_reg[psr_pkg::DIFF_W-1]}}, s1_dy_reg}
                  * {{(psr_pkg::PROD_W-psr_pkg::SCALE_W){1'b0}}, cfg.y_scale};

    // Non-negative and below the grid size: every bit above the cell field clear
    assign x_ok = (prod_x[psr_pkg::PROD_W-1:psr_pkg::FRAC_SHIFT+psr_pkg::CELL_BITS] == '0);
    assign y_ok = (prod_y[psr_pkg::PROD_W-1:psr_pkg::FRAC_SHIFT+psr_pkg::CELL_BITS] == '0);

    // Dropped points leave nothing in the queue
    assign keep = s1_mode_reg || (s1_band_reg && x_ok && y_ok);
    assign push = advance && keep;

    always_comb
    begin
        push_data.is_read = s1_mode_reg;
        push_data.color   = s1_color_reg;
        if (s1_mode_reg)
        begin
            push_data.addr = s1_addr_reg;
        end
        else
        begin
            push_data.addr = {prod_y[psr_pkg::FRAC_SHIFT +: psr_pkg::CELL_BITS],
                              prod_x[psr_pkg::FRAC_SHIFT +: psr_pkg::CELL_BITS]};
        end
    end

endmodule

### sv/psr_queue.sv
// Short request queue between the front and back ends.
// Depends on psr_pkg for the entry type and depth.

module psr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psr_pkg::entry_t push_data,
    input  logic            pop,
    output psr_pkg::entry_t head,
    output logic            empty,
    output logic            full
);

    psr_pkg::entry_t                 slot_reg [psr_pkg::QUEUE_DEPTH];
    logic [psr_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [psr_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [psr_pkg::QPTR_W:0]        count_reg;
    logic [psr_pkg::QPTR_W:0]        count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (psr_pkg::QPTR_W+1)'(psr_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/psr_back.sv
// Back end: clears the cell store after reset, then performs point writes and
// read-and-clear requests, holding each read result in an output register.
// Depends on psr_pkg; fed from psr_queue.

module psr_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  psr_pkg::entry_t              head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         ready_for_items,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [psr_pkg::COLOR_W-1:0]  out_color,
    output logic                         out_written
);

    // Cell store: written flag above the colour
    logic [psr_pkg::COLOR_W:0]           mem [psr_pkg::CELLS];
    logic [psr_pkg::COLOR_W:0]           rdata_reg;

    psr_pkg::back_state_t                state_reg;
    psr_pkg::back_state_t                state_next;
    logic [psr_pkg::CELL_ADDR_W-1:0]     clr_cnt_reg;
    logic [psr_pkg::CELL_ADDR_W-1:0]     raddr_reg;
    logic                                out_valid_reg;
    logic [psr_pkg::COLOR_W-1:0]         out_color_reg;
    logic                                out_written_reg;

    logic                                read_go;
    logic                                we;
    logic [psr_pkg::CELL_ADDR_W-1:0]     waddr;
    logic [psr_pkg::COLOR_W:0]           wdata;
    logic                                rd_en;
    logic                                load_out;

    // A read may start only while the output register is empty
    assign read_go = !empty && head.is_read && !out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psr_pkg::B_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = psr_pkg::B_IDLE;
                end
            end
            psr_pkg::B_IDLE:
            begin
                if (read_go)
                begin
                    state_next = psr_pkg::B_RESP;
                end
            end
            psr_pkg::B_RESP:
            begin
                state_next = psr_pkg::B_IDLE;
            end
            default:
            begin
                state_next = psr_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop      = 1'b0;
        we       = 1'b0;
        waddr    = head.addr;
        wdata    = '0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            psr_pkg::B_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
            end
            psr_pkg::B_IDLE:
            begin
                if (!empty && !head.is_read)
                begin
                    pop   = 1'b1;
                    we    = 1'b1;
                    wdata = {1'b1, head.color};
                end
                else if (read_go)
                begin
                    pop   = 1'b1;
                    rd_en = 1'b1;
                end
            end
            psr_pkg::B_RESP:
            begin
                we       = 1'b1;
                waddr    = raddr_reg;
                load_out = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign ready_for_items = (state_reg != psr_pkg::B_CLEAR);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psr_pkg::B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == psr_pkg::B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raddr_reg <= head.addr;
        end
        if (load_out)
        begin
            out_color_reg   <= rdata_reg[psr_pkg::COLOR_W-1:0];
            out_written_reg <= rdata_reg[psr_pkg::COLOR_W];
        end
    end

    // Store write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Store read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[head.addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_color   = out_color_reg;
    assign out_written = out_written_reg;

endmodule

### sv/point_slice_rasterizer_top.sv
// Top level of the point slice rasterizer: register port, front end, queue, back end.
// Depends on psr_pkg, psr_front, psr_queue and psr_back.
//
// Point requests (s_tuser = 0) are band-tested and mapped to a cell of the
// 128 x 128 store in the front end at one per cycle while the queue has room;
// a kept point costs one store write in the back end, also one per cycle
// when no pixel request is being answered. A pixel request (s_tuser = 1)
// returns one result on the master side: its cell is read on the store's single
// read port, then zero is written back, and it waits while an earlier result is
// still held in the output register. Points outside the band or the grid give
// no result. After reset the back end clears all 16384 cells of the store, one
// cell a cycle; s_tready stays low meanwhile, register writes are taken as
// ever. Registers may be written only while no request is in flight.

module point_slice_rasterizer_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x[15:0], point_y[31:16], point_z[47:32], point_color[79:48],
    // read_row[86:80], read_column[93:87], zero [95:94]
    input  logic [psr_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode[0]
    input  logic                             s_tuser,
    // Master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_color[31:0]
    output logic [psr_pkg::M_TDATA_W-1:0]    m_tdata,
    // pixel_written[0]
    output logic                             m_tuser,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psr_pkg::PADDR_W-1:0]      paddr,
    input  logic [psr_pkg::PDATA_W-1:0]      pwdata,
    output logic [psr_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    psr_pkg::cfg_t                 cfg_reg;
    psr_pkg::reg_index_t           reg_index;
    logic                          reg_write;

    psr_pkg::entry_t               push_data;
    psr_pkg::entry_t               head;
    logic                          push;
    logic                          pop;
    logic                          q_empty;
    logic                          q_full;
    logic                          back_ready;

    // Register port
    assign pready    = 1'b1;
    assign reg_index = psr_pkg::reg_index_t'(paddr[psr_pkg::PADDR_W-1:2]);
    assign reg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min   <= psr_pkg::X_MIN_RESET;
            cfg_reg.y_min   <= psr_pkg::Y_MIN_RESET;
            cfg_reg.x_scale <= psr_pkg::X_SCALE_RESET;
            cfg_reg.y_scale <= psr_pkg::Y_SCALE_RESET;
            cfg_reg.center  <= psr_pkg::CENTER_RESET;
            cfg_reg.half    <= psr_pkg::HALF_RESET;
        end
        else if (reg_write)
        begin
            unique case (reg_index)
                psr_pkg::REG_X_MIN:   cfg_reg.x_min   <= pwdata[psr_pkg::COORD_BITS-1:0];
                psr_pkg::REG_Y_MIN:   cfg_reg.y_min   <= pwdata[psr_pkg::COORD_BITS-1:0];
                psr_pkg::REG_X_SCALE: cfg_reg.x_scale <= pwdata[psr_pkg::SCALE_W-1:0];
                psr_pkg::REG_Y_SCALE: cfg_reg.y_scale <= pwdata[psr_pkg::SCALE_W-1:0];
                psr_pkg::REG_CENTER:  cfg_reg.center  <= pwdata[psr_pkg::COORD_BITS-1:0];
                psr_pkg::REG_HALF:    cfg_reg.half    <= pwdata[psr_pkg::HALF_W-1:0];
                default:              cfg_reg.half    <= cfg_reg.half;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_index)
            psr_pkg::REG_X_MIN:   prdata = {16'd0, cfg_reg.x_min};
            psr_pkg::REG_Y_MIN:   prdata = {16'd0, cfg_reg.y_min};
            psr_pkg::REG_X_SCALE: prdata = {16'd0, cfg_reg.x_scale};
            psr_pkg::REG_Y_SCALE: prdata = {16'd0, cfg_reg.y_scale};
            psr_pkg::REG_CENTER:  prdata = {16'd0, cfg_reg.center};
            psr_pkg::REG_HALF:    prdata = {17'd0, cfg_reg.half};
            default:              prdata = '0;
        endcase
    end

    // Front end
    psr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (back_ready),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .in_z      (s_tdata[47:32]),
        .in_color  (s_tdata[79:48]),
        .in_row    (s_tdata[86:80]),
        .in_col    (s_tdata[93:87]),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Request queue
    psr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back end
    psr_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (q_empty),
        .pop             (pop),
        .ready_for_items (back_ready),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_color       (m_tdata),
        .out_written     (m_tuser)
    );

endmodule
